// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sts_pkg.sv -----
// ---------------------------------------------------------------------------
// sts_pkg
// types, codes and constants shared by the sum tree sampler modules
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sts_pkg;

  // default geometry
  localparam int DEF_LEAF_COUNT    = 1024;
  localparam int DEF_PRIORITY_BITS = 32;
  localparam int DEF_PAYLOAD_BITS  = 32;

  // transaction field widths
  localparam int OPCODE_W = 2;
  localparam int IDX_W    = 10;
  localparam int AMOUNT_W = 42;
  localparam int PAY_W    = 32;
  localparam int PRIO_W   = 32;
  localparam int TOTAL_W  = 42;
  localparam int COUNT_W  = 11;

  // configuration
  localparam int CFG_W        = 11;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;
  localparam int CAP_RESET    = 1024;
  localparam logic REG_ACTIVE_CAPACITY = 1'b0;

  // q1.16 fraction
  localparam int FRAC_BITS = 16;
  localparam int FRAC_ONE  = 65536;
  localparam int FRAC_W    = FRAC_BITS + 1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_UPDATE = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                 opcode;
    logic [IDX_W-1:0]    leaf_index;
    logic [AMOUNT_W-1:0] amount;
    logic                use_fraction;
    logic [PAY_W-1:0]    payload_in;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   found_index;
    logic [PAY_W-1:0]   found_payload;
    logic [PRIO_W-1:0]  found_priority;
    logic [TOTAL_W-1:0] total_mass;
    logic [COUNT_W-1:0] stored_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET,
    ST_SET_LEAF,
    ST_SET_UP,
    ST_MUL_INIT,
    ST_MUL,
    ST_DESC_INIT,
    ST_DESC,
    ST_FIN_RD,
    ST_FIN
  } state_t;

  // node pointer operations
  typedef enum logic [2:0] {
    N_HOLD,
    N_INC,
    N_ROOT,
    N_LEAF,
    N_PARENT,
    N_DESCEND
  } nop_t;

  // node write data select
  typedef enum logic [1:0] {
    W_ZERO,
    W_PRIO,
    W_SUM
  } wsel_t;

  typedef struct packed {
    logic  accept;
    nop_t  n_op;
    logic  rd_child;
    logic  node_we;
    wsel_t wr_sel;
    logic  pay_we;
    logic  pay_clr;
    logic  delta_ld;
    logic  mul_init;
    logic  mul_step;
    logic  mass_frac;
    logic  leaf_ld;
    logic  out_ld;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic at_root;
    logic at_leaf;
    logic clear_done;
    logic mul_done;
  } stat_t;

endpackage

// ----- hw/rtl/sts_ctrl.sv -----
// ---------------------------------------------------------------------------
// sts_ctrl
// sequencer for clear, insert/update walk-up, sample descent, read and result hand-off
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sts_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sts_pkg::op_t   in_op,
  input  logic           in_frac,
  output logic           out_valid,
  input  logic           out_stall,
  output sts_pkg::cmd_t  cmd,
  input  sts_pkg::stat_t stat
);

  sts_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;

  assign accept    = in_valid && (state_r == sts_pkg::ST_IDLE);
  assign in_stall  = (state_r != sts_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sts_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.n_op     = sts_pkg::N_HOLD;
    cmd.wr_sel   = sts_pkg::W_ZERO;
    unique case (state_r)
      sts_pkg::ST_CLEAR: begin
        cmd.node_we = 1'b1;
        cmd.pay_clr = 1'b1;
        cmd.n_op    = sts_pkg::N_INC;
        if (stat.clear_done) begin
          state_nxt = sts_pkg::ST_IDLE;
        end
      end
      sts_pkg::ST_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          unique case (in_op)
            sts_pkg::OP_INSERT, sts_pkg::OP_UPDATE: state_nxt = sts_pkg::ST_SET;
            sts_pkg::OP_SAMPLE: begin
              state_nxt = in_frac ? sts_pkg::ST_MUL_INIT : sts_pkg::ST_DESC_INIT;
            end
            sts_pkg::OP_READ: state_nxt = sts_pkg::ST_FIN_RD;
            default: state_nxt = sts_pkg::ST_IDLE;
          endcase
        end
      end
      sts_pkg::ST_SET: begin
        cmd.n_op   = sts_pkg::N_LEAF;
        cmd.pay_we = (stat.op == sts_pkg::OP_INSERT);
        state_nxt  = sts_pkg::ST_SET_LEAF;
      end
      sts_pkg::ST_SET_LEAF: begin
        cmd.node_we  = 1'b1;
        cmd.wr_sel   = sts_pkg::W_PRIO;
        cmd.delta_ld = 1'b1;
        cmd.n_op     = sts_pkg::N_PARENT;
        state_nxt    = sts_pkg::ST_SET_UP;
      end
      sts_pkg::ST_SET_UP: begin
        cmd.node_we = 1'b1;
        cmd.wr_sel  = sts_pkg::W_SUM;
        if (stat.at_root) begin
          state_nxt = sts_pkg::ST_FIN_RD;
        end else begin
          cmd.n_op = sts_pkg::N_PARENT;
        end
      end
      sts_pkg::ST_MUL_INIT: begin
        cmd.mul_init = 1'b1;
        state_nxt    = sts_pkg::ST_MUL;
      end
      sts_pkg::ST_MUL: begin
        if (stat.mul_done) begin
          cmd.mass_frac = 1'b1;
          state_nxt     = sts_pkg::ST_DESC_INIT;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      sts_pkg::ST_DESC_INIT: begin
        cmd.n_op     = sts_pkg::N_ROOT;
        cmd.rd_child = 1'b1;
        state_nxt    = sts_pkg::ST_DESC;
      end
      sts_pkg::ST_DESC: begin
        if (stat.at_leaf) begin
          state_nxt = sts_pkg::ST_FIN_RD;
        end else begin
          cmd.n_op     = sts_pkg::N_DESCEND;
          cmd.rd_child = 1'b1;
        end
      end
      sts_pkg::ST_FIN_RD: begin
        // sample already sits on its leaf node, everything else jumps there
        cmd.n_op    = (stat.op == sts_pkg::OP_SAMPLE) ? sts_pkg::N_HOLD : sts_pkg::N_LEAF;
        cmd.leaf_ld = 1'b1;
        state_nxt   = sts_pkg::ST_FIN;
      end
      sts_pkg::ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_ld = 1'b1;
          state_nxt  = sts_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sts_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  `ASSERT_IMPLIES(a_out_ld_free, cmd.out_ld, !out_valid_r || !out_stall, "result overwrote a pending transaction")
  `ASSERT_NEXT(a_out_ld_valid, cmd.out_ld, out_valid_r, "loaded result not presented")
  `ASSERT_IMPLIES(a_sample_at_leaf, (state_r == sts_pkg::ST_FIN) && (stat.op == sts_pkg::OP_SAMPLE), stat.at_leaf, "sample finished above leaf level")

endmodule

// ----- hw/rtl/sts_datapath.sv -----
// ---------------------------------------------------------------------------
// sts_datapath
// node sum and payload memories, ring/count state, multiply and descent logic
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sts_datapath #(
  parameter int LEAF_COUNT    = sts_pkg::DEF_LEAF_COUNT,
  parameter int PRIORITY_BITS = sts_pkg::DEF_PRIORITY_BITS,
  parameter int PAYLOAD_BITS  = sts_pkg::DEF_PAYLOAD_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sts_pkg::in_item_t         in_data,
  input  logic [sts_pkg::CFG_W-1:0] cap_i,
  input  sts_pkg::cmd_t             cmd,
  output sts_pkg::stat_t            stat,
  output sts_pkg::out_item_t        out_data
);

  localparam int LEAF_BITS  = $clog2(LEAF_COUNT);
  localparam int NODE_BITS  = LEAF_BITS + 1;
  localparam int NODE_DEPTH = 2 * LEAF_COUNT;
  localparam int FIRST_LEAF = LEAF_COUNT - 1;
  localparam int LAST_NODE  = 2 * LEAF_COUNT - 2;
  localparam int SUM_BITS   = PRIORITY_BITS + LEAF_BITS;
  localparam int CNT_BITS   = LEAF_BITS + 1;
  localparam int MASS_BITS  = (sts_pkg::AMOUNT_W > SUM_BITS) ? sts_pkg::AMOUNT_W : SUM_BITS;
  localparam int SAT_W      = (sts_pkg::AMOUNT_W > PRIORITY_BITS) ?
                              sts_pkg::AMOUNT_W : PRIORITY_BITS;
  localparam int CMP_W      = (sts_pkg::CFG_W > CNT_BITS) ? sts_pkg::CFG_W : CNT_BITS;
  localparam int PROD_BITS  = SUM_BITS + sts_pkg::FRAC_W;

  // memories
  logic [SUM_BITS-1:0]     node_mem [NODE_DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_mem  [LEAF_COUNT];
  logic [SUM_BITS-1:0]     node_q_r;
  logic [PAYLOAD_BITS-1:0] pay_q_r;

  // control state
  logic [NODE_BITS-1:0]  n_r, n_nxt;
  logic [LEAF_BITS-1:0]  wpos_r, wpos_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic [SUM_BITS-1:0]   total_r;

  // item registers
  sts_pkg::op_t            op_r;
  logic [LEAF_BITS-1:0]    leaf_r, leaf_nxt;
  logic [PRIORITY_BITS-1:0] prio_r;
  logic [PAYLOAD_BITS-1:0] payload_r;
  logic [SUM_BITS-1:0]     delta_r;
  logic [MASS_BITS-1:0]    mass_r;
  logic [PROD_BITS-1:0]    acc_r;
  logic [PROD_BITS-1:0]    mcand_r;
  logic [sts_pkg::FRAC_W-1:0] mplier_r;
  sts_pkg::out_item_t      out_r;

  // combinational
  logic [CMP_W-1:0]         cap_ext;
  logic [CNT_BITS-1:0]      cap_eff;
  logic [LEAF_BITS-1:0]     pos;
  logic [CNT_BITS-1:0]      pos_inc;
  logic [CNT_BITS-1:0]      count_inc;
  logic [SAT_W-1:0]         amt_ext;
  logic [SAT_W-1:0]         prio_max_ext;
  logic [PRIORITY_BITS-1:0] in_prio;
  logic [sts_pkg::FRAC_W-1:0] frac;
  logic [NODE_BITS-1:0]     child_l;
  logic                     go_left;
  logic [MASS_BITS-1:0]     node_mass;
  logic [NODE_BITS-1:0]     node_raddr;
  logic [SUM_BITS-1:0]      node_wdata;
  logic                     pay_wen;
  logic [LEAF_BITS-1:0]     pay_waddr;
  logic [PAYLOAD_BITS-1:0]  pay_wdata;
  logic                     accept_ins;

  // effective capacity: zero acts as one, clipped to the leaf count
  always_comb begin
    cap_ext = CMP_W'(cap_i);
    if (cap_ext == '0) begin
      cap_eff = CNT_BITS'(1);
    end else if (cap_ext > CMP_W'(LEAF_COUNT)) begin
      cap_eff = CNT_BITS'(LEAF_COUNT);
    end else begin
      cap_eff = CNT_BITS'(cap_ext);
    end
  end

  assign pos        = (CNT_BITS'(wpos_r) < cap_eff) ? wpos_r : '0;
  assign pos_inc    = CNT_BITS'(pos) + CNT_BITS'(1);
  assign wpos_nxt   = (pos_inc == cap_eff) ? '0 : LEAF_BITS'(pos_inc);
  assign count_inc  = count_r + CNT_BITS'(1);
  assign count_nxt  = (count_inc < cap_eff) ? count_inc : cap_eff;
  assign accept_ins = cmd.accept && (in_data.opcode == sts_pkg::OP_INSERT);

  assign amt_ext      = SAT_W'(in_data.amount);
  assign prio_max_ext = SAT_W'({PRIORITY_BITS{1'b1}});
  assign in_prio      = (amt_ext > prio_max_ext) ? PRIORITY_BITS'(prio_max_ext)
                                                 : PRIORITY_BITS'(amt_ext);

  assign frac = (mass_r > MASS_BITS'(sts_pkg::FRAC_ONE)) ?
                sts_pkg::FRAC_W'(sts_pkg::FRAC_ONE) : mass_r[sts_pkg::FRAC_W-1:0];

  // descent step on the left child sum
  assign node_mass = MASS_BITS'(node_q_r);
  assign go_left   = (mass_r <= node_mass);
  assign child_l   = {n_r[NODE_BITS-2:0], 1'b1};

  always_comb begin
    case (cmd.n_op)
      sts_pkg::N_HOLD:    n_nxt = n_r;
      sts_pkg::N_INC:     n_nxt = n_r + NODE_BITS'(1);
      sts_pkg::N_ROOT:    n_nxt = '0;
      sts_pkg::N_LEAF:    n_nxt = NODE_BITS'(FIRST_LEAF) + NODE_BITS'(leaf_r);
      sts_pkg::N_PARENT:  n_nxt = (n_r - NODE_BITS'(1)) >> 1;
      sts_pkg::N_DESCEND: n_nxt = go_left ? child_l : child_l + NODE_BITS'(1);
      default:            n_nxt = n_r;
    endcase
  end

  assign node_raddr = cmd.rd_child ? {n_nxt[NODE_BITS-2:0], 1'b1} : n_nxt;
  assign leaf_nxt   = cmd.leaf_ld ? LEAF_BITS'(n_nxt - NODE_BITS'(FIRST_LEAF)) : leaf_r;

  always_comb begin
    case (cmd.wr_sel)
      sts_pkg::W_ZERO: node_wdata = '0;
      sts_pkg::W_PRIO: node_wdata = SUM_BITS'(prio_r);
      sts_pkg::W_SUM:  node_wdata = node_q_r + delta_r;
      default:         node_wdata = '0;
    endcase
  end

  always_comb begin
    pay_wen   = 1'b0;
    pay_waddr = leaf_r;
    pay_wdata = payload_r;
    if (cmd.pay_clr) begin
      pay_wen   = (n_r < NODE_BITS'(LEAF_COUNT));
      pay_waddr = LEAF_BITS'(n_r);
      pay_wdata = '0;
    end else if (cmd.pay_we) begin
      pay_wen = 1'b1;
    end
  end

  // node sum memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.node_we) begin
      node_mem[n_r] <= node_wdata;
    end
    node_q_r <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (pay_wen) begin
      pay_mem[pay_waddr] <= pay_wdata;
    end
    pay_q_r <= pay_mem[leaf_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r     <= '0;
      wpos_r  <= '0;
      count_r <= '0;
      total_r <= '0;
    end else begin
      n_r <= n_nxt;
      if (accept_ins) begin
        wpos_r  <= wpos_nxt;
        count_r <= count_nxt;
      end
      // mirror of the root node
      if (cmd.node_we && (n_r == '0)) begin
        total_r <= node_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    leaf_r <= leaf_nxt;
    if (cmd.accept) begin
      op_r      <= in_data.opcode;
      leaf_r    <= accept_ins ? pos : LEAF_BITS'(in_data.leaf_index);
      prio_r    <= in_prio;
      payload_r <= PAYLOAD_BITS'(in_data.payload_in);
      mass_r    <= MASS_BITS'(in_data.amount);
    end
    if (cmd.delta_ld) begin
      delta_r <= SUM_BITS'(prio_r) - node_q_r;
    end
    if (cmd.mul_init) begin
      acc_r    <= '0;
      mcand_r  <= PROD_BITS'(total_r);
      mplier_r <= frac;
    end
    if (cmd.mul_step) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
    if (cmd.mass_frac) begin
      mass_r <= MASS_BITS'(acc_r >> sts_pkg::FRAC_BITS);
    end
    if (cmd.n_op == sts_pkg::N_DESCEND) begin
      mass_r <= go_left ? mass_r : mass_r - node_mass;
    end
    if (cmd.out_ld) begin
      out_r.found_index    <= sts_pkg::IDX_W'(leaf_r);
      out_r.found_payload  <= sts_pkg::PAY_W'(pay_q_r);
      out_r.found_priority <= sts_pkg::PRIO_W'(node_q_r);
      out_r.total_mass     <= sts_pkg::TOTAL_W'(total_r);
      out_r.stored_count   <= sts_pkg::COUNT_W'(count_r);
    end
  end

  assign out_data        = out_r;
  assign stat.op         = op_r;
  assign stat.at_root    = (n_r == '0);
  assign stat.at_leaf    = (n_r >= NODE_BITS'(FIRST_LEAF));
  assign stat.clear_done = (n_r == NODE_BITS'(LAST_NODE));
  assign stat.mul_done   = (mplier_r == '0);

  `ASSERT_NEXT(a_root_total, cmd.node_we && (n_r == '0), total_r == $past(node_wdata), "total lost root write")
  `ASSERT_NEXT(a_mass_shrinks, cmd.n_op == sts_pkg::N_DESCEND, mass_r <= $past(mass_r), "descent mass grew")

endmodule

// ----- hw/rtl/sum_tree_priority_sampler_unit.sv -----
// ---------------------------------------------------------------------------
// sum_tree_priority_sampler_unit
// Binary sum tree sampler with insert, update, sample and read transactions.
// After reset the unit sweeps its node and payload memories to zero, one node
// a cycle, and holds in_stall high until that is done; the configuration
// port works throughout. Each transaction then runs alone. A read passes
// through the ST_FIN_RD and ST_FIN states to the output register. Insert and
// update do one read-modify-write of the node memory for each tree level on
// the way to the root. Sample by mass does one node memory read for each
// level of the descent; sample by fraction first adds a shift-add multiply
// of the total, one fraction bit a cycle. Results sit in an output register,
// so the next transaction is taken while a result still waits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sum_tree_priority_sampler_unit #(
  parameter int LEAF_COUNT    = sts_pkg::DEF_LEAF_COUNT,
  parameter int PRIORITY_BITS = sts_pkg::DEF_PRIORITY_BITS,
  parameter int PAYLOAD_BITS  = sts_pkg::DEF_PAYLOAD_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sts_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sts_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sts_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sts_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sts_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  logic [sts_pkg::CFG_W-1:0] cap_r;
  logic                      cap_sel;
  sts_pkg::cmd_t             cmd;
  sts_pkg::stat_t            stat;

  assign pready  = 1'b1;
  assign cap_sel = (paddr[sts_pkg::CFG_ADDR_W-1] == sts_pkg::REG_ACTIVE_CAPACITY);
  assign prdata  = cap_sel ? sts_pkg::CFG_DATA_W'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= sts_pkg::CFG_W'(sts_pkg::CAP_RESET);
    end else if (psel && penable && pwrite && pready && cap_sel) begin
      cap_r <= pwdata[sts_pkg::CFG_W-1:0];
    end
  end

  sts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_data.opcode),
    .in_frac   (in_data.use_fraction),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  sts_datapath #(
    .LEAF_COUNT    (LEAF_COUNT),
    .PRIORITY_BITS (PRIORITY_BITS),
    .PAYLOAD_BITS  (PAYLOAD_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cap_i    (cap_r),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
